/* rtl/opp_pkg.sv */
`default_nettype none

package opp_pkg;

  // Fixed field widths of a word on either channel.
  localparam int unsigned CoefW  = 32;
  localparam int unsigned IndexW = 9;

  // Control of the top-level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } opp_state_e;

  // Token that travels down the chain of cells beside the data.
  typedef struct packed {
    logic vld;
    logic last;
  } opp_tok_t;

endpackage

`default_nettype wire

/* rtl/opp_store.sv */
`default_nettype none

// Coefficient stores: one write port, one registered read port per store.
// The token of the read is registered alongside the data.
module opp_store #(
  parameter int unsigned MAX_TERMS = 512,
  parameter int unsigned AddrW     = $clog2(MAX_TERMS)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          wr_en_i,
  input  wire  [AddrW-1:0]             wr_addr_i,
  input  wire  [opp_pkg::CoefW-1:0]    wr_a_i,
  input  wire  [opp_pkg::CoefW-1:0]    wr_b_i,
  input  wire  opp_pkg::opp_tok_t      rd_tok_i,
  input  wire  [AddrW-1:0]             rd_addr_a_i,
  input  wire  [AddrW-1:0]             rd_addr_b_i,
  output opp_pkg::opp_tok_t            rd_tok_o,
  output logic [opp_pkg::CoefW-1:0]    rd_a_o,
  output logic [opp_pkg::CoefW-1:0]    rd_b_o
);

  logic [opp_pkg::CoefW-1:0] first_mem  [MAX_TERMS];
  logic [opp_pkg::CoefW-1:0] second_mem [MAX_TERMS];
  opp_pkg::opp_tok_t         tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      first_mem[wr_addr_i]  <= wr_a_i;
      second_mem[wr_addr_i] <= wr_b_i;
    end
    rd_a_o <= first_mem[rd_addr_a_i];
    rd_b_o <= second_mem[rd_addr_b_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= rd_tok_i;
    end
  end

  assign rd_tok_o = tok_q;

endmodule

`default_nettype wire

/* rtl/opp_mac.sv */
`default_nettype none

// Multiply cell followed by an accumulate cell. The product is registered
// before it reaches the adder; the sum wraps at the coefficient width.
module opp_mac (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          clear_i,
  input  wire  opp_pkg::opp_tok_t      tok_i,
  input  wire  [opp_pkg::CoefW-1:0]    a_i,
  input  wire  [opp_pkg::CoefW-1:0]    b_i,
  output opp_pkg::opp_tok_t            done_o,
  output logic [opp_pkg::CoefW-1:0]    acc_o
);

  opp_pkg::opp_tok_t         mul_tok_q;
  logic [opp_pkg::CoefW-1:0] mul_q;
  logic [opp_pkg::CoefW-1:0] mul_d;
  logic [opp_pkg::CoefW-1:0] acc_q;
  logic [opp_pkg::CoefW-1:0] acc_d;

  // Only the low word of the product is kept, which is the same for signed
  // and unsigned operands.
  assign mul_d = a_i * b_i;

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (mul_tok_q.vld) begin
      acc_d = acc_q + mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_tok_q <= '0;
    end else begin
      mul_tok_q <= tok_i;
    end
  end

  assign done_o.vld  = mul_tok_q.vld & mul_tok_q.last;
  assign done_o.last = mul_tok_q.last;
  assign acc_o       = acc_q;

endmodule

`default_nettype wire

/* rtl/online_polynomial_product.sv */
`default_nettype none

// A word at index i gives its result once the single multiply-accumulate
// chain has visited the i + 1 stored pairs; an overflowing word skips the
// chain. A new word is accepted only after the previous result has entered
// the output register.
// Reset: asynchronous, active low; clears the index counter and all control,
// while the coefficient stores stay undefined until written.

module online_polynomial_product #(
  parameter int unsigned MAX_TERMS = 512
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               start_new_i,
  input  wire  signed [opp_pkg::CoefW-1:0]  a_coef_i,
  input  wire  signed [opp_pkg::CoefW-1:0]  b_coef_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [opp_pkg::CoefW-1:0]  product_coef_o,
  output logic        [opp_pkg::IndexW-1:0] coef_index_o,
  output logic                              overflow_o
);

  localparam int unsigned AddrW = $clog2(MAX_TERMS);
  localparam int unsigned CntW  = $clog2(MAX_TERMS + 1);

  // Sequencer state.
  opp_pkg::opp_state_e state_q, state_d;

  // Index of the next word; it saturates at the store capacity.
  logic [CntW-1:0]  next_index_q, next_index_d;
  logic [CntW-1:0]  cur_idx;
  logic [31:0]      cur_idx_ext;
  logic             cur_ovf;
  logic             accept;

  // Issue cell: walks j from zero to the current index.
  logic [AddrW-1:0] idx_q;
  logic [AddrW-1:0] j_q;
  logic             issue_act_q;
  logic             issue_en;
  opp_pkg::opp_tok_t issue_tok;

  // Result held while the output register may still be occupied.
  logic                       ovf_q;
  logic [opp_pkg::IndexW-1:0] res_idx_q;

  opp_pkg::opp_tok_t          rd_tok;
  logic [opp_pkg::CoefW-1:0]  rd_a;
  logic [opp_pkg::CoefW-1:0]  rd_b;
  opp_pkg::opp_tok_t          mac_done;
  logic [opp_pkg::CoefW-1:0]  acc;

  logic                       out_free;
  logic                       load_out;

  assign accept      = in_valid_i & in_ready_o;
  assign cur_idx     = start_new_i ? '0 : next_index_q;
  assign cur_idx_ext = 32'(cur_idx);
  assign cur_ovf     = (cur_idx_ext >= MAX_TERMS);
  assign out_free    = ~out_valid_o | out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      opp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cur_ovf ? opp_pkg::ST_DONE : opp_pkg::ST_RUN;
        end
      end
      opp_pkg::ST_RUN: begin
        if (mac_done.vld) begin
          state_d = opp_pkg::ST_DONE;
        end
      end
      opp_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = opp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = opp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    issue_en   = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      opp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      opp_pkg::ST_RUN: begin
        issue_en = issue_act_q;
      end
      opp_pkg::ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    next_index_d = next_index_q;
    if (accept) begin
      next_index_d = cur_ovf ? CntW'(MAX_TERMS) : cur_idx + 1'b1;
    end
  end

  assign issue_tok.vld  = issue_en;
  assign issue_tok.last = (j_q == idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= opp_pkg::ST_IDLE;
      next_index_q <= '0;
      issue_act_q  <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_index_q <= next_index_d;
      if (accept) begin
        issue_act_q <= ~cur_ovf;
      end else if (issue_en && issue_tok.last) begin
        issue_act_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q     <= cur_idx[AddrW-1:0];
      j_q       <= '0;
      ovf_q     <= cur_ovf;
      res_idx_q <= cur_ovf ? '0 : cur_idx_ext[opp_pkg::IndexW-1:0];
    end else if (issue_en) begin
      j_q <= j_q + 1'b1;
    end
    if (load_out) begin
      product_coef_o <= ovf_q ? '0 : acc;
      coef_index_o   <= res_idx_q;
      overflow_o     <= ovf_q;
    end
  end

  // The pair is written on acceptance, so the first read in the next cycle
  // already sees it; entry idx - j of the second store pairs with entry j.
  opp_store #(
    .MAX_TERMS (MAX_TERMS),
    .AddrW     (AddrW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (accept & ~cur_ovf),
    .wr_addr_i   (cur_idx[AddrW-1:0]),
    .wr_a_i      (a_coef_i),
    .wr_b_i      (b_coef_i),
    .rd_tok_i    (issue_tok),
    .rd_addr_a_i (j_q),
    .rd_addr_b_i (idx_q - j_q),
    .rd_tok_o    (rd_tok),
    .rd_a_o      (rd_a),
    .rd_b_o      (rd_b)
  );

  opp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept),
    .tok_i   (rd_tok),
    .a_i     (rd_a),
    .b_i     (rd_b),
    .done_o  (mac_done),
    .acc_o   (acc)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

// Testbench for the online polynomial product.
// Every accepted input word below capacity stores one coefficient pair, and
// the block answers with one product coefficient. The sender and the receiver
// run as separate processes with random gaps. A scoreboard queue holds the
// product coefficients that are still owed, in order.

module testbench;

  localparam int unsigned CoefW       = opp_pkg::CoefW;
  localparam int unsigned IndexW      = opp_pkg::IndexW;
  localparam int unsigned MaxTerms    = 512;
  localparam int unsigned ItemsTotal  = 900;
  // The one long product starts once this many words have gone in.
  localparam int unsigned LongAt      = 150;
  // The receiver holds off once, after this many results, for this many cycles.
  localparam int unsigned HoldAfter   = 60;
  localparam int unsigned HoldCycles  = 400;
  // The drain outlasts a word at the deepest index, so it catches any late stray word.
  localparam int unsigned DrainCycles = 600;
  // The limit lies above the slowest run, the hold included.
  localparam int unsigned CycleLimit  = 2_500_000;
  localparam int unsigned NumDirected = 19;

  typedef struct packed {
    logic [CoefW-1:0]  coef;
    logic [IndexW-1:0] power;
    logic              ovf;
  } coef_word_t;

  // One row of the directed table. Where fixed is set, the expected word is
  // typed in the row. Otherwise the predictor supplies it.
  typedef struct packed {
    logic              restart;
    logic [CoefW-1:0]  a;
    logic [CoefW-1:0]  b;
    logic              fixed;
    logic [CoefW-1:0]  coef;
    logic [IndexW-1:0] power;
    logic              ovf;
  } directed_word_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     start_new_i    = 1'b0;
  logic signed [CoefW-1:0]  a_coef_i       = '0;
  logic signed [CoefW-1:0]  b_coef_i       = '0;
  logic                     out_ready_i    = 1'b0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  logic signed [CoefW-1:0]  product_coef_o;
  logic        [IndexW-1:0] coef_index_o;
  logic                     overflow_o;

  // The predictor's own copy of the coefficient stores and the index counter.
  logic [CoefW-1:0] a_terms [MaxTerms];
  logic [CoefW-1:0] b_terms [MaxTerms];
  int unsigned      term_count = 0;

  coef_word_t  owed_coefs [$];
  int unsigned mismatch_count = 0;
  int unsigned words_sent     = 0;
  int unsigned results_taken  = 0;
  int unsigned cycle_count    = 0;
  bit          tx_burst       = 1'b0;
  bit          rx_burst       = 1'b0;
  bit          long_done      = 1'b0;

  // The directed table covers these cases in turn. The first words arrive
  // with no start after reset, so they must land at index zero and onwards.
  // Next come the signed extremes at index zero, where the wrapped product
  // can be read off directly. A short product is then drained with zero
  // pairs, and the table ends with a restart in the middle of a product.
  directed_word_t directed_words [NumDirected] = '{
    '{1'b0, 32'h0000_0003, 32'h0000_0005, 1'b1, 32'h0000_000F, 9'd0, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 9'd0, 1'b0},
    '{1'b1, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, 9'd0, 1'b0},
    '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0000_0001, 9'd0, 1'b0},
    '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h8000_0000, 9'd0, 1'b0},
    '{1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 9'd0, 1'b0},
    '{1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 9'd0, 1'b0},
    '{1'b1, 32'h0000_0001, 32'h0000_0002, 1'b1, 32'h0000_0002, 9'd0, 1'b0},
    '{1'b0, 32'h0000_0003, 32'h0000_0004, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 9'd0, 1'b0},
    '{1'b0, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0,         9'd0, 1'b0},
    '{1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 9'd0, 1'b0}
  };

  online_polynomial_product #(
    .MAX_TERMS(MaxTerms)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_new_i   (start_new_i),
    .a_coef_i      (a_coef_i),
    .b_coef_i      (b_coef_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .product_coef_o(product_coef_o),
    .coef_index_o  (coef_index_o),
    .overflow_o    (overflow_o)
  );

  always #4 clk_i = ~clk_i;

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Predicts the product coefficient for one accepted word. The pair is
  // stored at the current index, and the convolution sum runs over every pair
  // stored so far in this product. The 32-bit operands keep only the low half
  // of each product, which gives the wrapping arithmetic. At full capacity
  // the pair is dropped, and the word reports overflow with zeros.
  function automatic coef_word_t predict_product_coef(logic restart,
                                                      logic [CoefW-1:0] a,
                                                      logic [CoefW-1:0] b);
    coef_word_t       res;
    logic [CoefW-1:0] acc;
    int unsigned      pos;
    if (restart) term_count = 0;
    res = '{coef: '0, power: '0, ovf: 1'b1};
    if (term_count >= MaxTerms) begin
      term_count = MaxTerms;
      return res;
    end
    pos          = term_count;
    a_terms[pos] = a;
    b_terms[pos] = b;
    acc          = '0;
    for (int unsigned j = 0; j <= pos; j++) acc += a_terms[j] * b_terms[pos - j];
    term_count = pos + 1;
    res        = '{coef: acc, power: pos[IndexW-1:0], ovf: 1'b0};
    return res;
  endfunction

  // Most coefficients are fully random. Zeros and the signed extremes are
  // mixed in so that wrap-around in the accumulator gets exercised often.
  function automatic logic [CoefW-1:0] random_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_result(logic [CoefW-1:0] coef, logic [IndexW-1:0] power,
                              logic ovf);
    coef_word_t want;
    if (owed_coefs.size() == 0) begin
      report_mismatch($sformatf("unexpected word coef=%h index=%0d overflow=%0b",
                                coef, power, ovf));
      return;
    end
    want = owed_coefs.pop_front();
    if (coef !== want.coef)
      report_mismatch($sformatf("product_coef %h, expected %h (index %0d)",
                                coef, want.coef, want.power));
    if (power !== want.power)
      report_mismatch($sformatf("coef_index %0d, expected %0d", power, want.power));
    if (ovf !== want.ovf)
      report_mismatch($sformatf("overflow %0b, expected %0b (index %0d)",
                                ovf, want.ovf, want.power));
  endtask

  // Offers one word and waits for the block to take it. The gap comes first.
  // Valid is lowered only when a real gap follows, so a word offered back to
  // back keeps valid high without a second assignment in the same step.
  task automatic send_word(logic restart, logic [CoefW-1:0] a, logic [CoefW-1:0] b,
                           logic fixed, coef_word_t fixed_word);
    coef_word_t  predicted;
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_new_i <= restart;
    a_coef_i    <= a;
    b_coef_i    <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_product_coef(restart, a, b);
    owed_coefs.push_back(fixed ? fixed_word : predicted);
    words_sent++;
  endtask

  // Stops offering words until every owed result has come back. At least one
  // edge always passes, so the lowered valid is never overridden in the same
  // step.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_coefs.size() != 0) @(posedge clk_i);
  endtask

  // Sends one product of len pairs. Where pad is set, it then sends len - 1
  // zero pairs that drain the upper half of the product.
  task automatic send_product(int unsigned len, logic restart, logic pad);
    for (int unsigned k = 0; k < len; k++)
      send_word(restart && (k == 0), random_coef(), random_coef(), 1'b0, '0);
    if (pad)
      for (int unsigned k = 1; k < len; k++) send_word(1'b0, '0, '0, 1'b0, '0);
  endtask

  // The receiver draws a stall before every result and has stretches with
  // none. It holds off once for a long stretch while the sender keeps
  // offering, so the block backs up and stalls its input.
  initial begin
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (results_taken == HoldAfter) stall = HoldCycles;
      else stall = rx_burst ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_result(product_coef_o, coef_index_o, overflow_o);
      results_taken++;
    end
  end

  initial begin
    directed_word_t row;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed part walks the table.
    for (int unsigned r = 0; r < NumDirected; r++) begin
      row = directed_words[r];
      send_word(row.restart, row.a, row.b, row.fixed,
                '{coef: row.coef, power: row.power, ovf: row.ovf});
    end
    wait_until_drained();

    // The random part is mostly short products with a start flag, some of
    // them drained with zero pairs. Roughly one in eight arrives without a
    // start and carries on from the previous index. One long product fills
    // the stores to capacity and then runs on into overflow, where the index
    // counter must saturate.
    while (words_sent < ItemsTotal) begin
      if (!long_done && words_sent >= LongAt) begin
        wait_until_drained();
        send_product(MaxTerms + 8, 1'b1, 1'b0);
        long_done = 1'b1;
      end else begin
        send_product($urandom_range(1, 12), $urandom_range(0, 7) != 0,
                     $urandom_range(0, 1) != 0);
      end
    end
    in_valid_i <= 1'b0;

    while (owed_coefs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/opp_pkg.sv
rtl/opp_store.sv
rtl/opp_mac.sv
rtl/online_polynomial_product.sv
tb/testbench.sv
